### design/ikc_pkg.sv
// ----------------------------------------------------------------------------
// ikc_pkg
// Shared constants, register codes and types of the 2D convolution filter.
// ----------------------------------------------------------------------------
package ikc_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_RADIUS_DEF = 2;
  localparam int COEF_FRAC_DEF  = 8;

  localparam int PIX_W   = 24;
  localparam int CH_W    = 8;
  localparam int COEF_W  = 12;
  localparam int COEF_N  = 5;
  localparam int ROW_W   = 60;
  localparam int WIDTH_W = 11;
  localparam int CFG_DW  = 64;
  localparam int CFG_AW  = 6;

  localparam logic [2:0] REG_RADIUS = 3'd0;
  localparam logic [2:0] REG_GRAY   = 3'd1;
  localparam logic [2:0] REG_WIDTH  = 3'd2;
  localparam logic [2:0] REG_COEF0  = 3'd3;
  localparam logic [2:0] REG_COEF1  = 3'd4;
  localparam logic [2:0] REG_COEF2  = 3'd5;
  localparam logic [2:0] REG_COEF3  = 3'd6;
  localparam logic [2:0] REG_COEF4  = 3'd7;

  localparam logic [1:0]         RADIUS_RESET = 2'd1;
  localparam logic [WIDTH_W-1:0] WIDTH_RESET  = 11'd1024;
  localparam logic [ROW_W-1:0]   COEF1_RESET  = 60'h100000;

  typedef logic [PIX_W-1:0] pix_t;

  typedef logic [COEF_N-1:0][ROW_W-1:0] coef_bank_t;

  // per-column control handed from the line stage to the window stage
  typedef struct packed {
    logic       row_end;
    logic       final_row;
    logic       emit_ok;
    logic [1:0] radius;
    logic [2:0] rows;
  } col_ctl_t;

  typedef struct packed {
    logic row_end;
    logic frame_end;
    logic last;
  } out_tag_t;

endpackage

### design/ikc_ram.sv
// ----------------------------------------------------------------------------
// ikc_ram
// Generic single-clock RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ikc_ram #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/ikc_line.sv
// ----------------------------------------------------------------------------
// ikc_line
// Row/column tracking and line store. Each RAM entry holds the pixels of one
// column from the rows above; a request reads it, adds the new pixel and
// writes the shifted column back. Emits one full column per non-stray request.
// ----------------------------------------------------------------------------
module ikc_line
  import ikc_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_RADIUS = MAX_RADIUS_DEF,
  localparam int XW = $clog2(MAX_WIDTH),
  localparam int VN = 2 * MAX_RADIUS + 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  pix_t                     in_pix,
  input  logic                     in_row_end,
  input  logic                     in_frame_end,
  input  logic                     in_drain,
  input  logic [1:0]               cfg_radius,
  input  logic [WIDTH_W-1:0]       cfg_width,
  output logic                     col_valid,
  input  logic                     col_ready,
  output logic [VN-1:0][PIX_W-1:0] col_vec,
  output logic [XW-1:0]            col_x,
  output col_ctl_t                 col_ctl
);

  localparam int HN = VN - 1;
  localparam int EW = HN * PIX_W;
  localparam int CW = (XW + 1 > WIDTH_W) ? XW + 1 : WIDTH_W;
  localparam logic [2:0]    ROWS_MAX = 3'(2 * MAX_RADIUS);
  localparam logic [1:0]    RAD_MAX  = 2'(MAX_RADIUS);
  localparam logic [XW-1:0] X_LAST   = XW'(MAX_WIDTH - 1);

  logic [XW-1:0] column_count, column_count_next;
  logic [2:0]    row_count, row_count_next;
  logic [1:0]    drain_count, drain_count_next;
  logic [XW:0]   row_len, row_len_next;

  logic          s1_valid;
  pix_t          s1_pix;
  logic          s1_drain;
  logic [XW-1:0] s1_x;
  col_ctl_t      s1_ctl;
  logic          fwd;
  logic [HN-1:0][PIX_W-1:0] fwd_data;

  logic [HN-1:0][PIX_W-1:0] rd_data, rd_eff, wr_data;
  pix_t          cur;

  logic          s1_go, take, stray, abandon, row_end_w, final_row, emit_ok;
  logic [1:0]    rad;
  logic [XW-1:0] x;
  logic [XW:0]   x_inc;
  logic [2:0]    rows_eff, rows_inc;

  assign s1_go    = s1_valid && col_ready;
  assign in_ready = !s1_valid || col_ready;

  always_comb begin
    if (cfg_radius == 2'd0) begin
      rad = 2'd1;
    end else if (cfg_radius > RAD_MAX) begin
      rad = RAD_MAX;
    end else begin
      rad = cfg_radius;
    end
  end

  assign stray     = in_drain && (drain_count == 2'd0);
  assign take      = in_valid && in_ready && !stray;
  assign abandon   = !in_drain && (drain_count != 2'd0);
  assign x         = abandon ? '0 : column_count;
  assign rows_eff  = abandon ? 3'd0 : row_count;
  assign x_inc     = {1'b0, x} + 1'b1;
  assign row_end_w = in_drain ? (x_inc >= row_len)
                   : (in_row_end || in_frame_end || (CW'(x_inc) >= CW'(cfg_width))
                      || (x == X_LAST));
  assign final_row = in_drain && row_end_w && (drain_count == 2'd1);
  assign emit_ok   = rows_eff >= {1'b0, rad};
  assign rows_inc  = (rows_eff < ROWS_MAX) ? rows_eff + 3'd1 : rows_eff;

  always_comb begin
    column_count_next = x_inc[XW-1:0];
    row_count_next    = rows_eff;
    drain_count_next  = abandon ? 2'd0 : drain_count;
    row_len_next      = row_len;
    if (row_end_w) begin
      column_count_next = '0;
      row_count_next    = rows_inc;
      if (in_drain) begin
        drain_count_next = drain_count - 2'd1;
        if (drain_count == 2'd1) begin
          row_count_next = 3'd0;
        end
      end else begin
        row_len_next = x_inc;
        if (in_frame_end) begin
          drain_count_next = rad;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= 3'd0;
      drain_count  <= 2'd0;
      row_len      <= (XW+1)'(1);
      s1_valid     <= 1'b0;
    end else begin
      if (take) begin
        column_count <= column_count_next;
        row_count    <= row_count_next;
        drain_count  <= drain_count_next;
        row_len      <= row_len_next;
        s1_valid     <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // same column written back at the edge it is read again: forward
  always_ff @(posedge clk) begin
    if (take) begin
      s1_pix   <= in_pix;
      s1_drain <= in_drain;
      s1_x     <= x;
      s1_ctl   <= '{row_end: row_end_w, final_row: final_row, emit_ok: emit_ok,
                    radius: rad, rows: rows_eff};
      fwd      <= s1_go && (s1_x == x);
      fwd_data <= wr_data;
    end
  end

  ikc_ram #(
    .W (EW),
    .D (MAX_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_x),
    .wdata (wr_data),
    .re    (take),
    .raddr (x),
    .rdata (rd_data)
  );

  assign rd_eff    = fwd ? fwd_data : rd_data;
  assign cur       = s1_drain ? rd_eff[0] : s1_pix;
  assign col_vec   = {rd_eff, cur};
  assign wr_data   = col_vec[HN-1:0];
  assign col_valid = s1_valid;
  assign col_x     = s1_x;
  assign col_ctl   = s1_ctl;

`ifndef ASSERT_OFF
  a_rows_bound: assert property (@(posedge clk) disable iff (rst)
    row_count <= ROWS_MAX)
    else $error("row count above limit");

  a_drain_bound: assert property (@(posedge clk) disable iff (rst)
    drain_count <= RAD_MAX)
    else $error("drain count above radius limit");

  a_fwd_match: assert property (@(posedge clk) disable iff (rst)
    take |=> (fwd == ($past(s1_go) && (s1_x == $past(s1_x)))))
    else $error("forward flag does not match write-back column");
`endif

endmodule

### design/ikc_window.sv
// ----------------------------------------------------------------------------
// ikc_window
// Horizontal window of column vectors. Replicates the left edge at column 0
// and, after a row end, shifts the last column in again to replicate the
// right edge. Selects the kernel taps with top-edge clamping.
// ----------------------------------------------------------------------------
module ikc_window
  import ikc_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_RADIUS = MAX_RADIUS_DEF,
  localparam int XW = $clog2(MAX_WIDTH),
  localparam int WN = 2 * MAX_RADIUS + 1
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               col_valid,
  output logic                               col_ready,
  input  logic [WN-1:0][PIX_W-1:0]           col_vec,
  input  logic [XW-1:0]                      col_x,
  input  col_ctl_t                           col_ctl,
  output logic                               tap_valid,
  input  logic                               tap_ready,
  output logic [WN-1:0][WN-1:0][PIX_W-1:0]   taps,
  output out_tag_t                           tap_tag
);

  localparam int IW = $clog2(WN);

  logic [WN-1:0][WN-1:0][PIX_W-1:0] win, win_next, taps_next;
  logic [1:0]    ext_left, ext_next, ext_j, j_next;
  logic [XW-1:0] hold_x;
  col_ctl_t      hold_ctl, ctl_use;
  out_tag_t      tag_next;
  logic          s3_free, step, emit;

  assign s3_free   = !tap_valid || tap_ready;
  assign col_ready = s3_free && (ext_left == 2'd0);
  assign step      = s3_free && ((ext_left != 2'd0) || col_valid);

  always_comb begin
    win_next = win;
    emit     = 1'b0;
    tag_next = '0;
    ext_next = ext_left;
    j_next   = ext_j;
    ctl_use  = hold_ctl;
    if (ext_left != 2'd0) begin
      win_next          = {win[WN-1], win[WN-1:1]};
      j_next            = ext_j + 2'd1;
      ext_next          = ext_left - 2'd1;
      emit              = hold_ctl.emit_ok &&
                          ((XW+1)'(hold_x) + (XW+1)'(j_next) >= (XW+1)'(hold_ctl.radius));
      tag_next.last      = (ext_left == 2'd1);
      tag_next.row_end   = (ext_left == 2'd1);
      tag_next.frame_end = (ext_left == 2'd1) && hold_ctl.final_row;
    end else if (col_valid) begin
      if (col_x == '0) begin
        win_next = {WN{col_vec}};
      end else begin
        win_next = {col_vec, win[WN-1:1]};
      end
      ctl_use       = col_ctl;
      emit          = col_ctl.emit_ok && (col_x >= XW'(col_ctl.radius));
      tag_next.last = !col_ctl.row_end;
      ext_next      = (col_ctl.row_end && col_ctl.emit_ok) ? col_ctl.radius : 2'd0;
      j_next        = 2'd0;
    end
  end

  always_comb begin
    int r2, rows_i, pi, bi;
    r2     = 2 * int'(ctl_use.radius);
    rows_i = int'(ctl_use.rows);
    for (int i = 0; i < WN; i++) begin
      for (int c = 0; c < WN; c++) begin
        pi = WN - 1 - r2 + c;
        bi = (r2 - i < rows_i) ? r2 - i : rows_i;
        if (i <= r2 && c <= r2) begin
          taps_next[i][c] = win_next[IW'(pi)][IW'(bi)];
        end else begin
          taps_next[i][c] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ext_left  <= 2'd0;
      ext_j     <= 2'd0;
      tap_valid <= 1'b0;
    end else begin
      if (step) begin
        ext_left <= ext_next;
        ext_j    <= j_next;
      end
      if (s3_free) begin
        tap_valid <= step && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      win <= win_next;
      if (ext_left == 2'd0) begin
        hold_x   <= col_x;
        hold_ctl <= col_ctl;
      end
      if (emit) begin
        taps    <= taps_next;
        tap_tag <= tag_next;
      end
    end
  end

`ifndef ASSERT_OFF
  a_ext_bound: assert property (@(posedge clk) disable iff (rst)
    (ext_left != 2'd0) |-> (ext_left <= hold_ctl.radius))
    else $error("edge replication count above radius");

  a_frame_row: assert property (@(posedge clk) disable iff (rst)
    (tap_valid && tap_tag.frame_end) |-> (tap_tag.row_end && tap_tag.last))
    else $error("frame end without row end");
`endif

endmodule

### design/ikc_mac.sv
// ----------------------------------------------------------------------------
// ikc_mac
// Gray conversion, per-tap multiply, row sums, total, clamp and the output
// register. Stages stall from the back.
// ----------------------------------------------------------------------------
module ikc_mac
  import ikc_pkg::*;
#(
  parameter int MAX_RADIUS     = MAX_RADIUS_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_DEF,
  localparam int WN = 2 * MAX_RADIUS + 1
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             tap_valid,
  output logic                             tap_ready,
  input  logic [WN-1:0][WN-1:0][PIX_W-1:0] taps,
  input  out_tag_t                         tap_tag,
  input  logic                             gray_mode,
  input  coef_bank_t                       coef,
  output logic                             out_valid,
  input  logic                             out_ready,
  output pix_t                             out_pix,
  output out_tag_t                         out_tag
);

  localparam int PW = CH_W + 1 + COEF_W;
  localparam int RW = PW + $clog2(WN);
  localparam int AW = RW + $clog2(WN);

  function automatic logic [CH_W-1:0] to_gray(pix_t p);
    logic [15:0] s;
    s = 16'(16'd77 * p[23:16]) + 16'(16'd150 * p[15:8]) + 16'(16'd29 * p[7:0]);
    return s[15:8];
  endfunction

  logic [WN-1:0][WN-1:0][COEF_W-1:0] kern;

  for (genvar i = 0; i < WN; i++) begin : g_ki
    for (genvar c = 0; c < WN; c++) begin : g_kc
      if (i < COEF_N && c < COEF_N) begin : g_on
        assign kern[i][c] = coef[i][COEF_W*c +: COEF_W];
      end else begin : g_off
        assign kern[i][c] = '0;
      end
    end
  end

  logic vA, vB, vC;
  logic rA, rB, rC, rD;
  out_tag_t tagA, tagB, tagC;

  logic [2:0][WN-1:0][WN-1:0][CH_W-1:0] chanA, chanA_next;
  logic [2:0][WN-1:0][WN-1:0][PW-1:0]   prodB, prodB_next;
  logic [2:0][WN-1:0][RW-1:0]           rowC, rowC_next;
  logic [2:0][CH_W-1:0]                 pixD_next;

  assign rD        = !out_valid || out_ready;
  assign rC        = !vC || rD;
  assign rB        = !vB || rC;
  assign rA        = !vA || rB;
  assign tap_ready = rA;

  always_comb begin
    for (int i = 0; i < WN; i++) begin
      for (int c = 0; c < WN; c++) begin
        for (int ch = 0; ch < 3; ch++) begin
          chanA_next[ch][i][c] = gray_mode ? to_gray(taps[i][c])
                                           : taps[i][c][CH_W*ch +: CH_W];
        end
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int i = 0; i < WN; i++) begin
        for (int c = 0; c < WN; c++) begin
          prodB_next[ch][i][c] = $signed({1'b0, chanA[ch][i][c]}) * $signed(kern[i][c]);
        end
      end
    end
  end

  always_comb begin
    logic signed [RW-1:0] acc;
    acc = '0;
    for (int ch = 0; ch < 3; ch++) begin
      for (int i = 0; i < WN; i++) begin
        acc = '0;
        for (int c = 0; c < WN; c++) begin
          acc = acc + RW'($signed(prodB[ch][i][c]));
        end
        rowC_next[ch][i] = acc;
      end
    end
  end

  always_comb begin
    logic signed [AW-1:0] tot;
    logic [AW-1:0]        shf;
    tot = '0;
    shf = '0;
    for (int ch = 0; ch < 3; ch++) begin
      tot = '0;
      for (int i = 0; i < WN; i++) begin
        tot = tot + AW'($signed(rowC[ch][i]));
      end
      shf = tot >> COEF_FRAC_BITS;
      if (tot < 0) begin
        pixD_next[ch] = '0;
      end else if (shf > AW'(255)) begin
        pixD_next[ch] = 8'hFF;
      end else begin
        pixD_next[ch] = shf[CH_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vA        <= 1'b0;
      vB        <= 1'b0;
      vC        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rA) vA <= tap_valid;
      if (rB) vB <= vA;
      if (rC) vC <= vB;
      if (rD) out_valid <= vC;
    end
  end

  always_ff @(posedge clk) begin
    if (rA && tap_valid) begin
      chanA <= chanA_next;
      tagA  <= tap_tag;
    end
    if (rB && vA) begin
      prodB <= prodB_next;
      tagB  <= tagA;
    end
    if (rC && vB) begin
      rowC <= rowC_next;
      tagC <= tagB;
    end
    if (rD && vC) begin
      out_pix <= pixD_next;
      out_tag <= tagC;
    end
  end

endmodule

### design/image_kernel_convolution.sv
// ----------------------------------------------------------------------------
// image_kernel_convolution
// Streaming 2D convolution of BGR pixels with replicated borders.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while the output accepts. A pixel that ends a row
// makes the window shift in radius right-edge copies and emit the last output
// pixels of that row, and the input stalls meanwhile. Otherwise one request
// per cycle is taken unless output back-pressure holds the pipeline; the
// column RAM does a single read and single write per cycle. A result is
// registered in the line, window and MAC stages. Outputs lag the input by
// radius rows and radius columns; after frame end, send radius rows of drain
// requests to flush the bottom rows. The line store needs no clearing after
// reset. Configuration may be written only while the filter is idle.
// ----------------------------------------------------------------------------
module image_kernel_convolution
  import ikc_pkg::*;
#(
  parameter int MAX_WIDTH      = MAX_WIDTH_DEF,
  parameter int MAX_RADIUS     = MAX_RADIUS_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [23:0]       s_tdata,   // blue, green, red
  input  logic              s_tlast,   // row_end
  input  logic [1:0]        s_tuser,   // frame_end, drain
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [23:0]       m_tdata,   // out_blue, out_green, out_red
  output logic              m_tlast,   // out_row_end
  output logic [1:0]        m_tuser    // out_frame_end, out_last
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int WN = 2 * MAX_RADIUS + 1;

  logic [1:0]         kernel_radius;
  logic               gray_mode;
  logic [WIDTH_W-1:0] image_width;
  coef_bank_t         coef_row;

  logic [2:0] reg_idx;
  logic       cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_radius <= RADIUS_RESET;
      gray_mode     <= 1'b0;
      image_width   <= WIDTH_RESET;
      coef_row      <= {{(3*ROW_W){1'b0}}, COEF1_RESET, {ROW_W{1'b0}}};
    end else if (cfg_wr) begin
      unique case (reg_idx) inside
        REG_RADIUS: kernel_radius <= pwdata[1:0];
        REG_GRAY:   gray_mode     <= pwdata[0];
        REG_WIDTH:  image_width   <= pwdata[WIDTH_W-1:0];
        REG_COEF0, REG_COEF1, REG_COEF2, REG_COEF3, REG_COEF4:
          coef_row[3'(reg_idx - REG_COEF0)] <= pwdata[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx) inside
      REG_RADIUS: prdata = CFG_DW'(kernel_radius);
      REG_GRAY:   prdata = CFG_DW'(gray_mode);
      REG_WIDTH:  prdata = CFG_DW'(image_width);
      REG_COEF0, REG_COEF1, REG_COEF2, REG_COEF3, REG_COEF4:
        prdata = CFG_DW'(coef_row[3'(reg_idx - REG_COEF0)]);
      default: prdata = '0;
    endcase
  end

  logic                             col_valid, col_ready;
  logic [WN-1:0][PIX_W-1:0]         col_vec;
  logic [XW-1:0]                    col_x;
  col_ctl_t                         col_ctl;
  logic                             tap_valid, tap_ready;
  logic [WN-1:0][WN-1:0][PIX_W-1:0] taps;
  out_tag_t                         tap_tag, out_tag;
  pix_t                             out_pix;

  ikc_line #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_line (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_pix       (s_tdata),
    .in_row_end   (s_tlast),
    .in_frame_end (s_tuser[0]),
    .in_drain     (s_tuser[1]),
    .cfg_radius   (kernel_radius),
    .cfg_width    (image_width),
    .col_valid    (col_valid),
    .col_ready    (col_ready),
    .col_vec      (col_vec),
    .col_x        (col_x),
    .col_ctl      (col_ctl)
  );

  ikc_window #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .col_valid (col_valid),
    .col_ready (col_ready),
    .col_vec   (col_vec),
    .col_x     (col_x),
    .col_ctl   (col_ctl),
    .tap_valid (tap_valid),
    .tap_ready (tap_ready),
    .taps      (taps),
    .tap_tag   (tap_tag)
  );

  ikc_mac #(
    .MAX_RADIUS     (MAX_RADIUS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .tap_valid (tap_valid),
    .tap_ready (tap_ready),
    .taps      (taps),
    .tap_tag   (tap_tag),
    .gray_mode (gray_mode),
    .coef      (coef_row),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_pix   (out_pix),
    .out_tag   (out_tag)
  );

  assign m_tdata = out_pix;
  assign m_tlast = out_tag.row_end;
  assign m_tuser = {out_tag.last, out_tag.frame_end};

endmodule

### dv/tb_image_kernel_convolution.sv
// ----------------------------------------------------------------------------
// tb_image_kernel_convolution
// Self-checking bench for the streaming 2D convolution filter. Frames of
// random BGR pixels, with drain rows, stray drains and abandoned drains, are
// sent under random settings of radius, gray mode, width and kernel. Each
// output pixel is checked against a behavioral filter kept in this bench.
// ----------------------------------------------------------------------------
module tb_image_kernel_convolution;
  import ikc_pkg::*;

  typedef struct packed {
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
    logic       row_end;
    logic       frame_end;
    logic       drain;
  } px_req_t;

  typedef struct {
    px_req_t q;
    int      n_exp;  // -1: predictor only
  } dir_row_t;

  typedef struct {
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
    logic       row_end;
    logic       frame_end;
    logic       last;
  } pix_res_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;
  logic              s_tvalid;
  logic              s_tready;
  logic [23:0]       s_tdata;   // blue, green, red
  logic              s_tlast;   // row_end
  logic [1:0]        s_tuser;   // frame_end, drain
  logic              m_tvalid;
  logic              m_tready;
  logic [23:0]       m_tdata;   // out_blue, out_green, out_red
  logic              m_tlast;   // out_row_end
  logic [1:0]        m_tuser;   // out_frame_end, out_last

  image_kernel_convolution dut (.*);

  // filter state mirrored in the bench
  logic [23:0] lstore [5][1024];
  int          col_cnt, row_cnt, drain_cnt, ring, last_len;
  logic [1:0]  rad_reg;
  logic        gray_reg;
  logic [10:0] width_reg;
  logic [59:0] coef_reg [5];

  pix_res_t expected_pixels [$];
  int       errors, mismatches, items_taken, pixels_out, frames_sent;
  bit       quiet, hold_req;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("tb_image_kernel_convolution: done, errors");
    $finish;
  end

  function automatic logic [7:0] sat8(longint s);
    if (s < 0) return 8'd0;
    s = s >>> 8;
    if (s > 255) return 8'd255;
    return s[7:0];
  endfunction

  function automatic longint tap(int i, int c);
    logic [11:0] v;
    v = coef_reg[i][12*c +: 12];
    return longint'($signed(v));
  endfunction

  function automatic pix_res_t filter_at(int xo, int xl, int rr);
    longint   s [3];
    int       back, slot, col, gv;
    longint   k;
    logic [23:0] p;
    pix_res_t o;
    s = '{0, 0, 0};
    for (int i = 0; i <= 2*rr; i++) begin
      back = 2*rr - i;
      if (back > row_cnt) back = row_cnt;
      slot = (ring + 5 - back) % 5;
      for (int c = 0; c <= 2*rr; c++) begin
        col = xo + c - rr;
        if (col < 0) col = 0;
        if (col > xl) col = xl;
        k = tap(i, c);
        p = lstore[slot][col];
        if (gray_reg) begin
          gv = (77*p[23:16] + 150*p[15:8] + 29*p[7:0]) >> 8;
          s[0] += longint'(gv) * k;
        end else begin
          for (int ch = 0; ch < 3; ch++) s[ch] += longint'(p[8*ch +: 8]) * k;
        end
      end
    end
    if (gray_reg) begin
      o.b = sat8(s[0]); o.g = o.b; o.r = o.b;
    end else begin
      o.b = sat8(s[0]); o.g = sat8(s[1]); o.r = sat8(s[2]);
    end
    o.row_end = 0; o.frame_end = 0; o.last = 0;
    return o;
  endfunction

  // one accepted request: update mirrored state, queue the pixels it emits
  function automatic int conv_predict(px_req_t q);
    int       x, rr, first, xo, n, w, prev;
    bit       rowend, fin;
    pix_res_t o;
    n = 0;
    fin = 0;
    if (q.drain) begin
      if (drain_cnt == 0) return 0;
      x = col_cnt;
      prev = (ring + 4) % 5;
      lstore[ring][x] = lstore[prev][x];
      rowend = (x + 1 >= last_len);
      fin = rowend && drain_cnt == 1;
    end else begin
      if (drain_cnt != 0) begin
        drain_cnt = 0; row_cnt = 0; col_cnt = 0;
      end
      x = col_cnt;
      lstore[ring][x] = {q.r, q.g, q.b};
      w = (width_reg == 0) ? 1 : width_reg;
      rowend = q.row_end || q.frame_end || x + 1 >= w || x + 1 >= 1024;
    end
    items_taken++;
    rr = (rad_reg == 0) ? 1 : (rad_reg > 2) ? 2 : rad_reg;
    if (row_cnt >= rr) begin
      if (rowend) first = (x >= rr) ? x - rr : 0;
      else first = (x >= rr) ? x - rr : x + 1;
      xo = first;
      while (xo <= x && (rowend || xo == first)) begin
        o = filter_at(xo, x, rr);
        o.row_end = rowend && xo == x;
        o.frame_end = fin && xo == x;
        o.last = !(rowend && xo < x);
        expected_pixels.push_back(o);
        n++;
        xo++;
      end
    end
    if (rowend) begin
      col_cnt = 0;
      ring = (ring + 1) % 5;
      if (row_cnt < 4) row_cnt++;
      if (q.drain) begin
        drain_cnt--;
        if (drain_cnt == 0) row_cnt = 0;
      end else begin
        last_len = x + 1;
        if (q.frame_end) drain_cnt = rr;
      end
    end else begin
      col_cnt = x + 1;
    end
    return n;
  endfunction

  task automatic apb_write(logic [2:0] idx, logic [63:0] val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 3'b000}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_RADIUS: rad_reg = val[1:0];
      REG_GRAY:   gray_reg = val[0];
      REG_WIDTH:  width_reg = val[10:0];
      default:    coef_reg[idx - REG_COEF0] = val[59:0];
    endcase
  endtask

  task automatic send_pixel(px_req_t q, int n_exp);
    int n;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {q.r, q.g, q.b};
    s_tlast <= q.row_end;
    s_tuser <= {q.drain, q.frame_end};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n = conv_predict(q);
    if (n_exp >= 0 && n != n_exp) begin
      errors++;
      $display("directed request: %0d pixels predicted, %0d listed", n, n_exp);
    end
  endtask

  task automatic settle();
    s_tvalid <= 0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [59:0] rand_coef_row(int mode);
    logic [59:0] v;
    for (int c = 0; c < 5; c++) begin
      case (mode)
        0: v[12*c +: 12] = 12'($signed($urandom_range(0, 160)) - 80);
        1: v[12*c +: 12] = 12'($urandom);
        2: v[12*c +: 12] = 12'h7FF;
        default: v[12*c +: 12] = 12'h800;
      endcase
    end
    return v;
  endfunction

  task automatic send_frame(int rows, int len, int rr);
    px_req_t q;
    int      d;
    for (int y = 0; y < rows; y++) begin
      for (int x = 0; x < len; x++) begin
        q.b = $urandom; q.g = $urandom; q.r = $urandom; q.drain = 0;
        q.frame_end = (y == rows - 1) && (x == len - 1);
        q.row_end = (x == len - 1) && (len < width_reg || $urandom_range(0, 1));
        send_pixel(q, -1);
      end
    end
    frames_sent++;
    case ($urandom_range(0, 9))
      0: d = 0;
      1, 2: d = $urandom_range(1, rr * len);
      default: d = rr * len;
    endcase
    for (int i = 0; i < d; i++) begin
      q = px_req_t'($urandom);
      q.drain = 1;
      send_pixel(q, -1);
    end
    if (d == rr * len) begin
      repeat ($urandom_range(0, 3)) begin
        q = px_req_t'($urandom);
        q.drain = 1;
        send_pixel(q, 0);
      end
    end
  endtask

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    m_tready <= 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 0;
        repeat (400) @(posedge clk);
        hold_req = 0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        m_tready <= 0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      m_tready <= 1;
    end
  end

  always @(posedge clk) begin
    pix_res_t e;
    if (!rst && m_tvalid && m_tready) begin
      pixels_out++;
      if (expected_pixels.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected output pixel %h", m_tdata);
      end else begin
        e = expected_pixels.pop_front();
        if (m_tdata !== {e.r, e.g, e.b} || m_tlast !== e.row_end
            || m_tuser !== {e.last, e.frame_end}) begin
          errors++;
          if (mismatches++ < 10)
            $display("pixel %0d: expected bgr %h/%h/%h tags %b%b%b, got %h tlast %b tuser %b",
                     pixels_out, e.b, e.g, e.r, e.row_end, e.frame_end, e.last,
                     m_tdata, m_tlast, m_tuser);
        end
      end
    end
  end

  initial begin
    dir_row_t dir_tab [22];
    int       rr, len, w, mode;
    rst = 1; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    s_tvalid = 0; s_tdata = 0; s_tlast = 0; s_tuser = 0;
    for (int i = 0; i < 5; i++)
      for (int j = 0; j < 1024; j++) lstore[i][j] = 0;
    col_cnt = 0; row_cnt = 0; drain_cnt = 0; ring = 0; last_len = 1;
    rad_reg = RADIUS_RESET; gray_reg = 0; width_reg = WIDTH_RESET;
    for (int i = 0; i < 5; i++) coef_reg[i] = 0;
    coef_reg[1] = COEF1_RESET;
    errors = 0; mismatches = 0; items_taken = 0; pixels_out = 0; frames_sent = 0;
    quiet = 0; hold_req = 0;

    // identity kernel at reset, 5-pixel rows ended by tlast or frame end
    dir_tab = '{
      '{'{8'h12, 8'h34, 8'h56, 1'b0, 1'b0, 1'b1}, 0},   // stray drain
      '{'{8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0}, 0},
      '{'{8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 1'b0}, 0},
      '{'{8'hAA, 8'h55, 8'hAA, 1'b0, 1'b0, 1'b0}, 0},
      '{'{8'h55, 8'hAA, 8'h55, 1'b0, 1'b0, 1'b0}, 0},
      '{'{8'hFF, 8'h00, 8'h80, 1'b1, 1'b0, 1'b0}, 0},
      '{'{8'h01, 8'h02, 8'h04, 1'b0, 1'b0, 1'b0}, 0},
      '{'{8'h08, 8'h10, 8'h20, 1'b0, 1'b0, 1'b0}, 1},
      '{'{8'h40, 8'h80, 8'hFF, 1'b0, 1'b0, 1'b0}, 1},
      '{'{8'h00, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b0}, 1},
      '{'{8'h7F, 8'h7F, 8'h7F, 1'b1, 1'b0, 1'b0}, 2},
      '{'{8'hFF, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b0}, 0},
      '{'{8'h00, 8'h00, 8'hFF, 1'b0, 1'b0, 1'b0}, 1},
      '{'{8'hC3, 8'h3C, 8'h99, 1'b0, 1'b0, 1'b0}, 1},
      '{'{8'h66, 8'h99, 8'h66, 1'b0, 1'b0, 1'b0}, 1},
      '{'{8'hFE, 8'h01, 8'hFE, 1'b0, 1'b1, 1'b0}, 2},   // frame end
      '{'{8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1}, 0},
      '{'{8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1}, 1},
      '{'{8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1}, 1},
      '{'{8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1}, 1},
      '{'{8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1}, 2},   // last drain
      '{'{8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1}, 0}    // stray drain
    };

    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (dir_tab[i]) send_pixel(dir_tab[i].q, dir_tab[i].n_exp);

    for (int ph = 0; items_taken < 450; ph++) begin
      settle();
      case (ph)
        0: begin rr = 2; w = 5; mode = 2; end
        1: begin rr = 1; w = 1024; mode = 3; end
        2: begin rr = 0; w = 7; mode = 0; end
        3: begin rr = 3; w = 1024; mode = 1; end
        default: begin
          rr = $urandom_range(0, 3);
          w = ($urandom_range(0, 3) == 0) ? 1024 : $urandom_range(5, 12);
          mode = ($urandom_range(0, 3) == 0) ? 1 : 0;
        end
      endcase
      apb_write(REG_RADIUS, 64'(rr));
      apb_write(REG_GRAY, 64'($urandom_range(0, 1)));
      apb_write(REG_WIDTH, 64'(w));
      apb_write(REG_COEF0, 64'(rand_coef_row(mode)));
      apb_write(REG_COEF1, 64'(rand_coef_row(mode)));
      apb_write(REG_COEF2, 64'(rand_coef_row(mode)));
      apb_write(REG_COEF3, 64'(rand_coef_row(mode)));
      apb_write(REG_COEF4, 64'(rand_coef_row(mode)));
      rr = (rr == 0) ? 1 : (rr > 2) ? 2 : rr;
      if (ph == 2) hold_req = 1;
      repeat ($urandom_range(1, 3)) begin
        quiet = items_taken >= 380;
        len = (w == 1024) ? $urandom_range(1, 12) : $urandom_range(1, w);
        if (w != 1024 && $urandom_range(0, 1)) len = w;
        send_frame($urandom_range(1, 5), len, rr);
      end
    end
    s_tvalid <= 0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    errors += expected_pixels.size();
    $display("%0d requests taken in %0d frames plus the directed set; %0d pixels checked",
             items_taken, frames_sent, pixels_out);
    $display("radius 0..3, gray and color, widths 5..1024, saturating kernels, drains");
    if (errors == 0) begin
      $display("tb_image_kernel_convolution: done, clean");
    end else begin
      $display("tb_image_kernel_convolution: done, errors");
    end
    $finish;
  end

endmodule
